/* rtl/kws_pkg.sv */
// Package: keyword table, widths and table helper functions for the keyword score filter
`timescale 1ns / 1ps
`default_nettype none
package kws_pkg;

  localparam int KW_COUNT      = 60;
  localparam int KW_MAX_LEN    = 9;
  localparam int KW_GROUP_SIZE = 8;
  localparam int KW_GROUPS     = (KW_COUNT + KW_GROUP_SIZE - 1) / KW_GROUP_SIZE;
  localparam int SCORE_W       = 7;
  localparam int PART_W        = 5;
  localparam int BYTE_W        = 8;

  typedef struct packed {
    logic [1:0]  chars;
    logic [1:0]  weight;
    logic [15:0] cp0;
    logic [15:0] cp1;
    logic [15:0] cp2;
  } kw_entry_t;

  localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
    '{2'd1, 2'd1, 16'h6CA1, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h9669, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h60CA, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h5446, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h9707, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h64BC, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h5413, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h50BB, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h9A97, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h7206, 16'h0000, 16'h0000},
    '{2'd2, 2'd1, 16'h8D22, 16'h5BCC, 16'h0000},
    '{2'd2, 2'd1, 16'h5BC6, 16'h7801, 16'h0000},
    '{2'd2, 2'd1, 16'h8BD1, 16'h5C40, 16'h0000},
    '{2'd1, 2'd1, 16'h7834, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h6253, 16'h0000, 16'h0000},
    '{2'd2, 2'd1, 16'h5343, 16'h4E07, 16'h0000},
    '{2'd1, 2'd1, 16'h7F5A, 16'h0000, 16'h0000},
    '{2'd2, 2'd1, 16'h8C28, 16'h8BB0, 16'h0000},
    '{2'd1, 2'd1, 16'h4E0D, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h4E86, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h9999, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h5403, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h5B9A, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h597D, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h4E25, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h6781, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h7AEF, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h62D2, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h7EDD, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h5DE8, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h5927, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h5FEB, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h770B, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h574F, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h5077, 16'h0000, 16'h0000},
    '{2'd1, 2'd1, 16'h9003, 16'h0000, 16'h0000},
    '{2'd2, 2'd1, 16'h53D1, 16'h73B0, 16'h0000},
    '{2'd1, 2'd2, 16'h0021, 16'h0000, 16'h0000},
    '{2'd1, 2'd2, 16'hFF01, 16'h0000, 16'h0000},
    '{2'd1, 2'd2, 16'h003F, 16'h0000, 16'h0000},
    '{2'd1, 2'd2, 16'hFF1F, 16'h0000, 16'h0000},
    '{2'd3, 2'd2, 16'h3002, 16'h3002, 16'h3002},
    '{2'd3, 2'd2, 16'h002E, 16'h002E, 16'h002E},
    '{2'd1, 2'd2, 16'h5371, 16'h0000, 16'h0000},
    '{2'd2, 2'd2, 16'h5929, 16'h5440, 16'h0000},
    '{2'd3, 2'd2, 16'h4E00, 16'h53E3, 16'h6C14},
    '{2'd2, 2'd2, 16'h79D8, 16'h5BC6, 16'h0000},
    '{2'd2, 2'd2, 16'h66B4, 16'h8DCC, 16'h0000},
    '{2'd2, 2'd2, 16'h66B4, 16'h6DA8, 16'h0000},
    '{2'd2, 2'd2, 16'h9A97, 16'h5C40, 16'h0000},
    '{2'd2, 2'd2, 16'h5C45, 16'h7136, 16'h0000},
    '{2'd2, 2'd2, 16'h5207, 16'h8BB0, 16'h0000},
    '{2'd2, 2'd2, 16'h89E3, 16'h5BC6, 16'h0000},
    '{2'd2, 2'd2, 16'h63ED, 16'h79D8, 16'h0000},
    '{2'd1, 2'd2, 16'h614C, 16'h0000, 16'h0000},
    '{2'd2, 2'd2, 16'h6CE8, 16'h610F, 16'h0000},
    '{2'd2, 2'd2, 16'h5C0F, 16'h5FC3, 16'h0000},
    '{2'd2, 2'd2, 16'h8B66, 16'h544A, 16'h0000},
    '{2'd1, 2'd2, 16'h4EBF, 16'h0000, 16'h0000},
    '{2'd1, 2'd3, 16'h4E07, 16'h0000, 16'h0000}
  };

  function automatic logic [3:0] kw_len(input int k);
    logic [15:0] cps [3];
    int n;
    cps = '{KW_TABLE[k].cp0, KW_TABLE[k].cp1, KW_TABLE[k].cp2};
    n = 0;
    for (int i = 0; i < 3; i++) begin
      if (i < int'(KW_TABLE[k].chars)) begin
        n = (cps[i] < 16'h0080) ? n + 1 : n + 3;
      end
    end
    return 4'(n);
  endfunction

  function automatic logic [7:0] kw_byte(input int k, input int p);
    logic [15:0] cps [3];
    logic [7:0]  bseq [KW_MAX_LEN];
    int n;
    cps = '{KW_TABLE[k].cp0, KW_TABLE[k].cp1, KW_TABLE[k].cp2};
    for (int j = 0; j < KW_MAX_LEN; j++) bseq[j] = 8'h00;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      if (i < int'(KW_TABLE[k].chars)) begin
        if (cps[i] < 16'h0080) begin
          bseq[n] = cps[i][7:0];
          n = n + 1;
        end else begin
          bseq[n]     = {4'hE, cps[i][15:12]};
          bseq[n + 1] = {2'b10, cps[i][11:6]};
          bseq[n + 2] = {2'b10, cps[i][5:0]};
          n = n + 3;
        end
      end
    end
    return bseq[p];
  endfunction

endpackage
`default_nettype wire

/* rtl/kws_in_if.sv */
// Interface: title byte input channel
`timescale 1ns / 1ps
`default_nettype none
interface kws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] title_byte;
  logic       last_byte;
  modport source (output valid, output title_byte, output last_byte, input ready);
  modport sink (input valid, input title_byte, input last_byte, output ready);
endinterface
`default_nettype wire

/* rtl/kws_out_if.sv */
// Interface: score result channel
`timescale 1ns / 1ps
`default_nettype none
interface kws_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] score_units;
  logic       is_flagged;
  modport source (output valid, output score_units, output is_flagged, input ready);
  modport sink (input valid, input score_units, input is_flagged, output ready);
endinterface
`default_nettype wire

/* rtl/kws_cfg_if.sv */
// Interface: threshold register write channel
`timescale 1ns / 1ps
`default_nettype none
interface kws_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] threshold_units;
  modport source (output valid, output threshold_units, input ready);
  modport sink (input valid, input threshold_units, output ready);
endinterface
`default_nettype wire

/* rtl/kws_cell.sv */
// Window cell: one byte of history with its valid flag, shifted on each transaction
`timescale 1ns / 1ps
`default_nettype none
module kws_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     clr,
  input  wire logic [kws_pkg::BYTE_W-1:0] d_byte,
  input  wire logic                     d_vld,
  output logic      [kws_pkg::BYTE_W-1:0] q_byte,
  output logic                          q_vld
);
  logic [kws_pkg::BYTE_W-1:0] byte_r;
  logic                       vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_vld & ~clr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byte_r <= d_byte;
    end
  end

  assign q_byte = byte_r;
  assign q_vld  = vld_r;
endmodule
`default_nettype wire

/* rtl/kws_match.sv */
// Pattern matcher: parallel compares against the window and per-pattern seen flags
`timescale 1ns / 1ps
`default_nettype none
module kws_match (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         acc,
  input  wire logic                         last,
  input  wire logic [kws_pkg::BYTE_W-1:0]   win_byte [kws_pkg::KW_MAX_LEN],
  input  wire logic                         win_vld  [kws_pkg::KW_MAX_LEN],
  output logic      [kws_pkg::KW_COUNT-1:0] flags_done
);
  logic [kws_pkg::KW_COUNT-1:0] seen_r;
  logic [kws_pkg::KW_COUNT-1:0] seen_nxt;
  logic [kws_pkg::KW_COUNT-1:0] hit;

  for (genvar k = 0; k < kws_pkg::KW_COUNT; k++) begin : g_pat
    localparam int L = int'(kws_pkg::kw_len(k));
    logic [kws_pkg::KW_MAX_LEN-1:0] eq;
    for (genvar p = 0; p < kws_pkg::KW_MAX_LEN; p++) begin : g_pos
      if (p < L) begin : g_cmp
        assign eq[p] = win_vld[L-1-p] && (win_byte[L-1-p] == kws_pkg::kw_byte(k, p));
      end else begin : g_pad
        assign eq[p] = 1'b1;
      end
    end
    assign hit[k] = &eq;
  end

  assign flags_done = seen_r | hit;

  always_comb begin
    seen_nxt = seen_r;
    if (acc) begin
      seen_nxt = last ? '0 : flags_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/kws_score.sv */
// Score pipeline: flag capture, group sums, total and threshold compare
`timescale 1ns / 1ps
`default_nettype none
module kws_score (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [kws_pkg::KW_COUNT-1:0]  flags,
  input  wire logic [kws_pkg::SCORE_W-1:0]   threshold,
  input  wire logic                          res_ready,
  output logic                               free,
  output logic                               res_valid,
  output logic      [kws_pkg::SCORE_W-1:0]   res_score,
  output logic                               res_flag
);
  logic                          a_v_r, p_v_r, o_v_r;
  logic [kws_pkg::KW_COUNT-1:0]  a_flags_r;
  logic [kws_pkg::PART_W-1:0]    part_r   [kws_pkg::KW_GROUPS];
  logic [kws_pkg::PART_W-1:0]    part_nxt [kws_pkg::KW_GROUPS];
  logic [kws_pkg::SCORE_W-1:0]   score_r, score_nxt;
  logic                          flag_r;
  logic                          o_free, p_free;

  assign o_free = !o_v_r || res_ready;
  assign p_free = !p_v_r || o_free;
  assign free   = !a_v_r || p_free;

  always_comb begin
    for (int g = 0; g < kws_pkg::KW_GROUPS; g++) begin
      part_nxt[g] = '0;
      for (int i = 0; i < kws_pkg::KW_GROUP_SIZE; i++) begin
        if (g * kws_pkg::KW_GROUP_SIZE + i < kws_pkg::KW_COUNT) begin
          if (a_flags_r[g * kws_pkg::KW_GROUP_SIZE + i]) begin
            part_nxt[g] = part_nxt[g] + kws_pkg::PART_W'(
              kws_pkg::KW_TABLE[g * kws_pkg::KW_GROUP_SIZE + i].weight);
          end
        end
      end
    end
    score_nxt = '0;
    for (int g = 0; g < kws_pkg::KW_GROUPS; g++) begin
      score_nxt = score_nxt + kws_pkg::SCORE_W'(part_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (free) a_v_r <= start;
      if (p_free) p_v_r <= a_v_r;
      if (o_free) o_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (free && start) a_flags_r <= flags;
    if (p_free && a_v_r) part_r <= part_nxt;
    if (o_free && p_v_r) begin
      score_r <= score_nxt;
      flag_r  <= (score_nxt >= threshold);
    end
  end

  assign res_valid = o_v_r;
  assign res_score = score_r;
  assign res_flag  = flag_r;
endmodule
`default_nettype wire

/* rtl/keyword_score_filter.sv */
// Top level: byte window chain, pattern matcher, score pipeline and threshold register
// Throughput: one title byte per cycle, back to back, while results are taken.
// Result path: flags are captured at the edge that accepts the last byte, then the group
// sums and then the total and compare are registered before the result is valid.
// The window cells and seen flags update in the cycle of each transaction.
// Reset (synchronous, rst_n low): window and flags clear, pipeline empty,
// threshold returns to 2.
`timescale 1ns / 1ps
`default_nettype none
module keyword_score_filter #(
  parameter int WINDOW_BYTES = 9
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kws_in_if.sink     in_ch,
  kws_out_if.source  out_ch,
  kws_cfg_if.sink    cfg_ch
);
  localparam int CELLS = WINDOW_BYTES - 1;

  logic                                 acc;
  logic                                 free;
  logic [kws_pkg::SCORE_W-1:0]          thr_r;
  logic [kws_pkg::BYTE_W-1:0]           cell_byte [CELLS];
  logic                                 cell_vld  [CELLS];
  logic [kws_pkg::BYTE_W-1:0]           win_byte  [kws_pkg::KW_MAX_LEN];
  logic                                 win_vld   [kws_pkg::KW_MAX_LEN];
  logic [kws_pkg::KW_COUNT-1:0]         flags_done;

  assign in_ch.ready = free;
  assign acc         = in_ch.valid && free;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= kws_pkg::SCORE_W'(2);
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.threshold_units;
    end
  end

  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    if (c == 0) begin : g_head
      kws_cell u_cell (
        .clk, .rst_n, .en(acc), .clr(in_ch.last_byte),
        .d_byte(in_ch.title_byte), .d_vld(1'b1),
        .q_byte(cell_byte[c]), .q_vld(cell_vld[c])
      );
    end else begin : g_body
      kws_cell u_cell (
        .clk, .rst_n, .en(acc), .clr(in_ch.last_byte),
        .d_byte(cell_byte[c-1]), .d_vld(cell_vld[c-1]),
        .q_byte(cell_byte[c]), .q_vld(cell_vld[c])
      );
    end
  end

  always_comb begin
    win_byte[0] = in_ch.title_byte;
    win_vld[0]  = 1'b1;
    for (int j = 1; j < kws_pkg::KW_MAX_LEN; j++) begin
      win_byte[j] = cell_byte[j-1];
      win_vld[j]  = cell_vld[j-1];
    end
  end

  kws_match u_match (
    .clk, .rst_n, .acc, .last(in_ch.last_byte),
    .win_byte, .win_vld, .flags_done
  );

  kws_score u_score (
    .clk, .rst_n,
    .start(acc && in_ch.last_byte),
    .flags(flags_done),
    .threshold(thr_r),
    .res_ready(out_ch.ready),
    .free,
    .res_valid(out_ch.valid),
    .res_score(out_ch.score_units),
    .res_flag(out_ch.is_flagged)
  );

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.last_byte |=> !cell_vld[0])
    else $error("window not cleared after last byte");

  a_fill_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_ch.last_byte |=> cell_vld[0])
    else $error("window head not filled");

  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.score_units <= kws_pkg::SCORE_W'(84))
    else $error("score out of range");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready && u_score.p_v_r && u_score.a_v_r |-> !in_ch.ready)
    else $error("accepted with pipeline full");
endmodule
`default_nettype wire

/* sim/keyword_score_filter_tb.sv */
// Testbench: keyword score filter, scored against an in-bench predictor of title scores
`timescale 1ns / 1ps
`default_nettype none
module keyword_score_filter_tb;

  typedef struct packed {
    logic [7:0] title_byte;
    logic       last_byte;
  } title_txn_t;

  typedef struct packed {
    logic [6:0] score_units;
    logic       is_flagged;
  } score_txn_t;

  localparam int WIN = 9;
  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kws_in_if  in_ch ();
  kws_out_if out_ch ();
  kws_cfg_if cfg_ch ();

  keyword_score_filter #(.WINDOW_BYTES(WIN)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  pat_bytes [kws_pkg::KW_COUNT][9];
  int          pat_len   [kws_pkg::KW_COUNT];
  int          pat_wt    [kws_pkg::KW_COUNT];
  logic [7:0]  win_bytes [WIN];
  int          win_fill;
  logic [59:0] seen_flags;
  logic [6:0]  thresh;

  title_txn_t  pending_bytes [$];
  score_txn_t  expected_scores [$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_off = 0;

  function automatic void encode_cp(input logic [15:0] cp, inout logic [7:0] b [9],
                                    inout int n);
    if (cp < 16'h0080) begin
      b[n] = cp[7:0];
      n++;
    end else begin
      b[n] = {4'hE, cp[15:12]};
      b[n + 1] = {2'b10, cp[11:6]};
      b[n + 2] = {2'b10, cp[5:0]};
      n += 3;
    end
  endfunction

  task automatic build_patterns();
    logic [7:0] b [9];
    logic [15:0] cps [3];
    int n;
    for (int k = 0; k < kws_pkg::KW_COUNT; k++) begin
      n = 0;
      cps = '{kws_pkg::KW_TABLE[k].cp0, kws_pkg::KW_TABLE[k].cp1, kws_pkg::KW_TABLE[k].cp2};
      for (int j = 0; j < 9; j++) b[j] = 8'h00;
      for (int i = 0; i < int'(kws_pkg::KW_TABLE[k].chars); i++) encode_cp(cps[i], b, n);
      for (int j = 0; j < 9; j++) pat_bytes[k][j] = b[j];
      pat_len[k] = n;
      pat_wt[k] = int'(kws_pkg::KW_TABLE[k].weight);
    end
  endtask

  task automatic clear_title();
    for (int i = 0; i < WIN; i++) win_bytes[i] = 8'h00;
    win_fill = 0;
    seen_flags = '0;
  endtask

  task automatic score_byte(input title_txn_t t);
    int sum;
    bit hit;
    score_txn_t r;
    for (int i = 0; i < WIN - 1; i++) win_bytes[i] = win_bytes[i + 1];
    win_bytes[WIN - 1] = t.title_byte;
    if (win_fill < WIN) win_fill++;
    for (int k = 0; k < kws_pkg::KW_COUNT; k++) begin
      if (pat_len[k] == 0 || pat_len[k] > win_fill) continue;
      hit = 1'b1;
      for (int j = 0; j < pat_len[k]; j++)
        if (win_bytes[WIN - pat_len[k] + j] != pat_bytes[k][j]) hit = 1'b0;
      if (hit) seen_flags[k] = 1'b1;
    end
    if (t.last_byte) begin
      sum = 0;
      for (int k = 0; k < kws_pkg::KW_COUNT; k++) if (seen_flags[k]) sum += pat_wt[k];
      r.score_units = 7'(sum);
      r.is_flagged = (sum >= int'(thresh));
      expected_scores.push_back(r);
      clear_title();
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic l);
    title_txn_t t;
    t.title_byte = b;
    t.last_byte = l;
    pending_bytes.push_back(t);
  endtask

  task automatic queue_pattern(input int k);
    for (int j = 0; j < pat_len[k]; j++) queue_byte(pat_bytes[k][j], 1'b0);
  endtask

  // random title: mostly keywords with filler, some noise
  task automatic queue_title();
    int n;
    int sel;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) queue_pattern($urandom_range(0, kws_pkg::KW_COUNT - 1));
      else if (sel < 8) queue_byte(8'($urandom), 1'b0);
      else queue_byte(pat_bytes[$urandom_range(0, kws_pkg::KW_COUNT - 1)]
                               [$urandom_range(0, 2)], 1'b0);
    end
    queue_byte(8'($urandom), 1'b1);
  endtask

  task automatic write_threshold(input logic [6:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.threshold_units <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    thresh = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_scores.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        title_txn_t t;
        t = pending_bytes.pop_front();
        score_byte(t);
        in_ch.valid <= 1'b1;
        in_ch.title_byte <= t.title_byte;
        in_ch.last_byte <= t.last_byte;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("keyword_score_filter_tb: done, errors");
      $finish;
    end else begin
      if (rst_n && out_ch.valid && out_ch.ready) begin
        score_txn_t e;
        if (expected_scores.size() == 0) begin
          $display("%0t: unexpected result score=%0d flag=%0b", $realtime,
                   out_ch.score_units, out_ch.is_flagged);
          errors++;
        end else begin
          e = expected_scores.pop_front();
          if (e.score_units != out_ch.score_units || e.is_flagged != out_ch.is_flagged) begin
            $display("%0t: mismatch expected score=%0d flag=%0b actual score=%0d flag=%0b",
                     $realtime, e.score_units, e.is_flagged, out_ch.score_units,
                     out_ch.is_flagged);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.title_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.threshold_units = 7'd0;
    build_patterns();
    clear_title();
    thresh = 7'd2;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, one-byte titles, every pattern, long runs
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h21, 1'b1);
    for (int k = 0; k < kws_pkg::KW_COUNT; k++) queue_pattern(k);
    queue_byte(8'h3F, 1'b1);
    queue_pattern(kws_pkg::KW_COUNT - 1);
    queue_pattern(15);
    queue_byte(8'h2E, 1'b0);
    queue_byte(8'h2E, 1'b1);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b1);
    drain();

    write_threshold(7'd0);
    for (int k = 0; k < kws_pkg::KW_COUNT; k++) queue_pattern(k);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h7F, 1'b1);
    drain();
    write_threshold(7'd84);
    for (int k = 0; k < kws_pkg::KW_COUNT; k++) queue_pattern(k);
    queue_byte(8'h01, 1'b1);
    drain();
    write_threshold(7'd127);
    for (int k = 0; k < kws_pkg::KW_COUNT; k++) queue_pattern(k);
    queue_byte(8'h01, 1'b1);
    drain();

    send_idle_pct = 7;
    recv_idle_pct = 62;
    write_threshold(7'd3);
    while (pending_bytes.size() < 120) queue_title();
    hold_off = 300;
    drain();

    send_idle_pct = 62;
    recv_idle_pct = 7;
    write_threshold(7'($urandom_range(0, 127)));
    while (pending_bytes.size() < 120) queue_title();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(7'd1);
    while (pending_bytes.size() < 120) queue_title();
    drain();

    if (errors == 0) begin
      $display("keyword_score_filter_tb: done, clean");
    end else begin
      $display("keyword_score_filter_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
rtl/kws_pkg.sv
rtl/kws_in_if.sv
rtl/kws_out_if.sv
rtl/kws_cfg_if.sv
rtl/kws_cell.sv
rtl/kws_match.sv
rtl/kws_score.sv
rtl/keyword_score_filter.sv
sim/keyword_score_filter_tb.sv
